// ===== rtl/core/crcsec_pkg.sv =====
// Shared types, constants and helpers for the bit-serial CRC encoder/checker.
// Used by every module under rtl/core; no dependencies.
package crcsec_pkg;

    localparam int MAX_DEGREE = 32;                       // widest generator supported
    localparam int DEG_W      = $clog2(MAX_DEGREE + 1);   // holds 1..MAX_DEGREE
    localparam int IDX_W      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int CFG_DEG_W  = 6;                        // degree register width
    localparam int TAPS_W     = 32;                       // taps register width
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // register indexes of the config port
    localparam logic [CFG_IDX_W-1:0] REG_TAPS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

    typedef enum logic
    {
        JOB_ECHO  = 1'b0,   // encode: echo bit, append remainder at frame end
        JOB_CHECK = 1'b1    // check: single status result at frame end
    } job_kind_t;

    typedef struct packed
    {
        logic [MAX_DEGREE-1:0] taps;       // already masked to the degree
        logic [DEG_W-1:0]      degree;     // effective degree, 1..MAX_DEGREE
        logic                  check_mode;
    } cfg_t;

    typedef struct packed
    {
        job_kind_t             kind;
        logic                  data_bit;
        logic                  frame_end;
        logic                  crc_error;
        logic [DEG_W-1:0]      degree;
        logic [MAX_DEGREE-1:0] remainder;
    } job_t;

    // clamp the programmed degree into 1..MAX_DEGREE
    function automatic logic [DEG_W-1:0] eff_degree(input logic [CFG_DEG_W-1:0] d);
        logic [DEG_W-1:0] res;
        if (d == '0)
            res = DEG_W'(1);
        else if (32'(d) > MAX_DEGREE)
            res = DEG_W'(MAX_DEGREE);
        else
            res = DEG_W'(d);
        return res;
    endfunction

    // ones in the low d bits
    function automatic logic [MAX_DEGREE-1:0] deg_mask(input logic [DEG_W-1:0] d);
        logic [MAX_DEGREE:0] one_hot;
        one_hot = (MAX_DEGREE + 1)'(1) << d;
        return MAX_DEGREE'(one_hot - (MAX_DEGREE + 1)'(1));
    endfunction

endpackage

// ===== rtl/core/crc_serial_encode_check.sv =====
// Top level of the bit-serial CRC encoder/checker with configurable generator.
// Depends on crcsec_pkg, crcsec_front, crcsec_fifo, crcsec_back.
//
// Usage:
//   Slave stream: one message bit per transaction in s_tdata[0], s_tlast on
//   the final bit of a message/frame. Master stream: one result per
//   transaction, m_tdata[0] the output bit, m_tlast the final result of a
//   frame, m_tuser[0] the CRC error flag (check mode).
//   Encode mode echoes every bit; after the frame's last bit the D-bit
//   remainder follows MSB first, last one flagged with m_tlast.
//   Check mode emits one transaction per frame, at its last bit.
//   Throughput: one input bit per cycle while s_tready is high; the output side
//   delivers one result per cycle while m_tready is high, so an encoded frame of
//   N bits yields N + D results. Each job is queued at its input edge and then
//   loaded into the output register before it appears on the master side.
//   A four-entry job queue sits between the division front end and the
//   result back end; s_tready drops only when that queue is full, e.g. while
//   the back end appends a remainder or m_tready is held low.
//   Reset: taps = 7, degree = 8, encode mode, remainder and queue empty.
//   Config writes (cfg_we/cfg_index/cfg_data) take effect the next cycle and
//   must only be issued while no results are pending.
module crc_serial_encode_check
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [crcsec_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [crcsec_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,   // [0] data_bit, [7:1] zero
    input  logic                                  s_tlast,   // frame_end
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [7:0]                            m_tdata,   // [0] out_bit, [7:1] zero
    output logic                                  m_tlast,   // is_last
    output logic [0:0]                            m_tuser    // [0] crc_error
);
    import crcsec_pkg::*;

    logic [TAPS_W-1:0]    taps_reg;
    logic [CFG_DEG_W-1:0] degree_reg;
    logic                 mode_reg;
    cfg_t                 cfg;

    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;
    job_t push_job;
    job_t head_job;
    logic out_bit;
    logic is_last;
    logic crc_error;

    // configuration registers; unknown index is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg   <= TAPS_W'(7);
            degree_reg <= CFG_DEG_W'(8);
            mode_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TAPS:   taps_reg   <= cfg_data[TAPS_W-1:0];
                REG_DEGREE: degree_reg <= cfg_data[CFG_DEG_W-1:0];
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // effective settings: clamped degree, taps limited below the degree
    always_comb
    begin
        cfg.degree     = eff_degree(degree_reg);
        cfg.taps       = MAX_DEGREE'(taps_reg) & deg_mask(cfg.degree);
        cfg.check_mode = mode_reg;
    end

    crcsec_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .data_bit  (s_tdata[0]),
        .frame_end (s_tlast),
        .push      (push),
        .push_job  (push_job),
        .fifo_full (fifo_full)
    );

    crcsec_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (pop),
        .head_job (head_job),
        .empty    (fifo_empty)
    );

    crcsec_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_job  (head_job),
        .empty     (fifo_empty),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_bit   (out_bit),
        .is_last   (is_last),
        .crc_error (crc_error)
    );

    assign m_tdata = {7'b0, out_bit};
    assign m_tlast = is_last;
    assign m_tuser = crc_error;

endmodule

// ===== rtl/core/crcsec_front.sv =====
// Front end: accepts input bits, runs the division register, queues jobs.
// Depends on crcsec_pkg.
module crcsec_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  crcsec_pkg::cfg_t      cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  data_bit,
    input  logic                  frame_end,
    output logic                  push,
    output crcsec_pkg::job_t      push_job,
    input  logic                  fifo_full
);
    import crcsec_pkg::*;

    logic [MAX_DEGREE-1:0] rem_reg;
    logic [MAX_DEGREE-1:0] rem_next;
    logic [MAX_DEGREE-1:0] mask;
    logic [MAX_DEGREE-1:0] r_cur;
    logic [MAX_DEGREE-1:0] r_upd;
    logic [IDX_W-1:0]      top_idx;
    logic                  top;
    logic                  accept;

    assign in_ready = !fifo_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        mask    = deg_mask(cfg.degree);
        r_cur   = rem_reg & mask;
        top_idx = IDX_W'(cfg.degree - DEG_W'(1));
        top     = r_cur[top_idx];
        if (cfg.check_mode)
        begin
            r_upd = ((r_cur << 1) | MAX_DEGREE'(data_bit)) & mask;
            if (top)
                r_upd = r_upd ^ cfg.taps;
        end
        else
        begin
            r_upd = (r_cur << 1) & mask;
            if (top ^ data_bit)
                r_upd = r_upd ^ cfg.taps;
        end
        rem_next = rem_reg;
        if (accept)
            rem_next = frame_end ? '0 : r_upd;

        push_job.kind      = cfg.check_mode ? JOB_CHECK : JOB_ECHO;
        push_job.data_bit  = data_bit;
        push_job.frame_end = frame_end;
        push_job.crc_error = (r_upd != '0);
        push_job.degree    = cfg.degree;
        push_job.remainder = r_upd;
        // check mode makes a result only at a frame end
        push = accept && (!cfg.check_mode || frame_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_reg <= '0;
        else
            rem_reg <= rem_next;
    end

endmodule

// ===== rtl/core/crcsec_fifo.sv =====
// Short job queue between front and back ends.
// Depends on crcsec_pkg.
module crcsec_fifo
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crcsec_pkg::job_t push_job,
    output logic             full,
    input  logic             pop,
    output crcsec_pkg::job_t head_job,
    output logic             empty
);
    import crcsec_pkg::*;

    job_t              mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FCNT_W-1:0] count_reg;
    logic [FCNT_W-1:0] count_next;

    assign full     = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = pop  ? PTR_W'(rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + FCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - FCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/crcsec_back.sv =====
// Back end: expands queued jobs into result transactions, one per cycle while
// out_ready allows, into a registered output stage. Depends on crcsec_pkg.
module crcsec_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  crcsec_pkg::job_t head_job,
    input  logic             empty,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_bit,
    output logic             is_last,
    output logic             crc_error
);
    import crcsec_pkg::*;

    logic [DEG_W-1:0] cnt_reg;      // 0: first result, k>0: remainder bit degree-k
    logic [DEG_W-1:0] cnt_next;
    logic             valid_reg;
    logic             valid_next;
    logic             bit_reg;
    logic             bit_next;
    logic             last_reg;
    logic             last_next;
    logic             err_reg;
    logic             err_next;
    logic             load;
    logic [IDX_W-1:0] pos;

    assign out_valid = valid_reg;
    assign out_bit   = bit_reg;
    assign is_last   = last_reg;
    assign crc_error = err_reg;

    always_comb
    begin
        load       = (!valid_reg || out_ready) && !empty;
        pop        = 1'b0;
        cnt_next   = cnt_reg;
        valid_next = valid_reg && !out_ready;
        bit_next   = bit_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        pos        = IDX_W'(head_job.degree - cnt_reg);
        if (load)
        begin
            valid_next = 1'b1;
            unique case (head_job.kind)
                JOB_CHECK:
                begin
                    bit_next  = 1'b0;
                    last_next = 1'b1;
                    err_next  = head_job.crc_error;
                    pop       = 1'b1;
                end
                JOB_ECHO:
                begin
                    err_next = 1'b0;
                    if (cnt_reg == '0)
                    begin
                        bit_next  = head_job.data_bit;
                        last_next = 1'b0;
                        if (head_job.frame_end)
                            cnt_next = DEG_W'(1);
                        else
                            pop = 1'b1;
                    end
                    else
                    begin
                        // remainder MSB first
                        bit_next  = head_job.remainder[pos];
                        last_next = (cnt_reg == head_job.degree);
                        if (cnt_reg == head_job.degree)
                        begin
                            pop      = 1'b1;
                            cnt_next = '0;
                        end
                        else
                            cnt_next = cnt_reg + DEG_W'(1);
                    end
                end
                default:
                begin
                    pop = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg  <= bit_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

endmodule

// ===== tb/sv/crc_serial_encode_check_tb.sv =====
// Self-checking testbench for crc_serial_encode_check: bit-serial CRC encode and check.
// Drives the bit stream and the config port and scores every result against a
// built-in division model. Depends on crcsec_pkg and the DUT only.
module crc_serial_encode_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import crcsec_pkg::*;

    // index the DUT has no register behind; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    // idle cycles after the last result before touching config (pipeline margin)
    localparam int SETTLE_CYCLES = 8;

    // one result transaction as seen on the master side
    typedef struct packed
    {
        logic out_bit;
        logic is_last;
        logic crc_error;
    } crc_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [0] data_bit, [7:1] zero
    logic                  s_tlast   = 1'b0; // frame_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;          // [0] out_bit, [7:1] zero
    logic                  m_tlast;          // is_last
    logic [0:0]            m_tuser;          // [0] crc_error

    // model copy of the DUT config and division state
    logic [31:0] gen_taps;
    logic [5:0]  gen_degree_reg;
    job_kind_t   gen_mode;
    logic [31:0] running_remainder;

    crc_result_t results_due[$];   // predicted results not yet seen on the master side
    int          mismatches = 0;

    // sender pacing
    bit offering     = 1'b0;   // s_tvalid currently held high by the sender
    bit sender_paced = 1'b1;   // 0: back-to-back transactions, no gaps
    int burst_left   = 4;

    // receiver control: a test asks for a long hold-off, the receiver counts it down
    int hold_request = 0;
    int hold_left    = 0;
    int ready_style  = 0;
    int style_left   = 0;
    int ready_phase  = 0;

    always #5 clk = ~clk;

    crc_serial_encode_check dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------
    // Division model
    // ------------------------------------------------------------------

    // programmed degree clamped into 1..MAX_DEGREE
    function automatic int active_degree();
        if (gen_degree_reg == '0)
            return 1;
        if (int'(gen_degree_reg) > MAX_DEGREE)
            return MAX_DEGREE;
        return int'(gen_degree_reg);
    endfunction

    // Advance the running remainder by one accepted bit and queue the
    // results it causes. Encode divides message * x^D (bit enters at the top),
    // check divides the frame as is (bit enters at the bottom).
    function automatic void divide_bit(input logic b, input logic last);
        int          d;
        logic [63:0] keep;
        logic [63:0] taps;
        logic [63:0] r;
        logic        top;
        crc_result_t res;
        d    = active_degree();
        keep = (64'd1 << d) - 64'd1;
        taps = {32'b0, gen_taps} & keep;
        r    = {32'b0, running_remainder} & keep;   // drops bits above a lowered degree
        top  = r[d-1];
        if (gen_mode == JOB_CHECK)
        begin
            r = ((r << 1) | {63'b0, b}) & keep;
            if (top)
                r ^= taps;
            if (last)
            begin
                res.out_bit   = 1'b0;
                res.is_last   = 1'b1;
                res.crc_error = (r != '0);
                results_due.push_back(res);
                r = '0;
            end
        end
        else
        begin
            r = (r << 1) & keep;
            if (top ^ b)
                r ^= taps;
            res.out_bit   = b;
            res.is_last   = 1'b0;
            res.crc_error = 1'b0;
            results_due.push_back(res);
            if (last)
            begin
                // remainder MSB first, only the final bit marked
                for (int k = 0; k < d; k++)
                begin
                    res.out_bit   = r[d-1-k];
                    res.is_last   = (k == d - 1);
                    res.crc_error = 1'b0;
                    results_due.push_back(res);
                end
                r = '0;
            end
        end
        running_remainder = r[31:0];
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare every master transaction with the oldest prediction
    // ------------------------------------------------------------------

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    always @(posedge clk)
    begin
        crc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result tdata=%0h tlast=%0b tuser=%0b",
                                        m_tdata, m_tlast, m_tuser));
            end
            else
            begin
                want = results_due.pop_front();
                if (m_tdata !== {7'b0, want.out_bit})
                    note_mismatch($sformatf("out_bit: expected tdata=%0h got %0h",
                                            {7'b0, want.out_bit}, m_tdata));
                if (m_tlast !== want.is_last)
                    note_mismatch($sformatf("is_last: expected %0b got %0b",
                                            want.is_last, m_tlast));
                if (m_tuser[0] !== want.crc_error)
                    note_mismatch($sformatf("crc_error: expected %0b got %0b",
                                            want.crc_error, m_tuser[0]));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: m_tready changes style every so often; a requested hold-off
    // overrides it for the given number of cycles.
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (style_left == 0)
        begin
            ready_style = $urandom_range(0, 3);
            style_left  = $urandom_range(20, 120);
        end
        else
        begin
            style_left--;
        end
        ready_phase++;
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case (ready_style)
                0:       m_tready <= 1'b1;                          // no stalls
                1:       m_tready <= ($urandom_range(0, 3) != 0);   // light random stalls
                2:       m_tready <= ($urandom_range(0, 2) == 0);   // heavy random stalls
                default: m_tready <= ((ready_phase % 7) < 4);       // periodic pattern
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender and config helpers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------

    // Offer one bit, wait for the handshake, predict, then maybe open a gap.
    task automatic send_bit(input logic b, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, b};
        s_tlast  <= last;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        divide_bit(b, last);
        @(negedge clk);
        if (sender_paced)
        begin
            if (burst_left == 0)
            begin
                s_tvalid <= 1'b0;
                offering = 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
            begin
                burst_left--;
            end
        end
    endtask

    // bits[len-1] goes first; frame_end on bits[0]
    task automatic send_frame(input logic [63:0] bits, input int len);
        for (int i = len - 1; i >= 0; i--)
            send_bit(bits[i], i == 0);
    endtask

    // Stop offering, wait until every predicted result has arrived, then let
    // the pipeline settle in case a frame is still being divided.
    task automatic wait_results_drained();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (results_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TAPS:   gen_taps       = value;
            REG_DEGREE: gen_degree_reg = value[5:0];
            REG_MODE:   gen_mode       = job_kind_t'(value[0]);
            default:    ;   // unknown index, ignored
        endcase
        @(negedge clk);
    endtask

    // Program all three registers while idle. Upper data bits of degree and
    // mode are random so the width masking gets exercised.
    task automatic configure(input logic [31:0] taps, input logic [5:0] degree,
                             input job_kind_t mode);
        logic [31:0] noise;
        noise = $urandom;
        wait_results_drained();
        cfg_write(REG_TAPS, taps);
        cfg_write(REG_DEGREE, {noise[31:6], degree});
        cfg_write(REG_MODE, {noise[31:1], mode});
    endtask

    function automatic logic [31:0] random_taps();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset config: taps 7, degree 8, encode
    task automatic test_reset_defaults();
        send_frame(64'b1011, 4);
        send_frame(64'b0, 1);
    endtask

    // degree 1 with taps above it, degree 0 (used as 1), 32, and 63 (used as 32)
    task automatic test_degree_extremes();
        configure(32'hFFFF_FFFF, 6'd1, JOB_ECHO);
        send_frame(64'b1, 1);
        configure(32'h0000_0003, 6'd0, JOB_ECHO);
        send_frame(64'b11, 2);
        configure(32'hFFFF_FFFF, 6'd32, JOB_ECHO);
        send_frame(64'b101, 3);
        configure(32'h04C1_1DB7, 6'd63, JOB_ECHO);
        send_frame(64'b10, 2);
    endtask

    // check mode: frame shorter than the degree, all-zero frame, parity pass
    task automatic test_check_basics();
        configure(32'd7, 6'd8, JOB_CHECK);
        send_frame(64'b101, 3);
        send_frame(64'b00, 2);
        configure(32'd1, 6'd1, JOB_CHECK);
        send_frame(64'b11, 2);
    endtask

    // degree lowered in the middle of a frame: remainder bits above it drop out
    task automatic test_midframe_reconfig();
        configure(32'd7, 6'd8, JOB_ECHO);
        send_bit(1'b1, 1'b0);
        send_bit(1'b1, 1'b0);
        configure(32'd3, 6'd4, JOB_ECHO);
        send_bit(1'b0, 1'b0);
        send_bit(1'b1, 1'b1);
    endtask

    // a write to the unused index must not alias onto degree or mode
    task automatic test_unused_index();
        wait_results_drained();
        cfg_write(REG_UNUSED, 32'h0000_0021);
        send_frame(64'b1, 1);
    endtask

    // receiver holds off for a long stretch while the sender streams without
    // gaps, so the job queue fills and s_tready drops
    task automatic test_backpressure();
        configure(32'h0000_1021, 6'd16, JOB_ECHO);
        sender_paced = 1'b0;
        hold_request = 80;
        repeat (8) send_frame({32'b0, $urandom}, 5);
        wait_results_drained();
        sender_paced = 1'b1;
    endtask

    // random messages in encode mode across several generators
    task automatic test_random_encode();
        logic [5:0] degree;
        int         sent;
        int         len;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       degree = 6'd1;
                1:       degree = 6'd32;
                2:       degree = 6'd0;
                3:       degree = 6'd63;
                4:       degree = 6'($urandom_range(0, 63));
                default: degree = 6'($urandom_range(1, 12));
            endcase
            configure(random_taps(), degree, JOB_ECHO);
            sender_paced = (phase % 3 != 1);
            sent = 0;
            while (sent < 2)
            begin
                len = $urandom_range(1, 12);
                send_frame({$urandom, $urandom}, len);
                sent += len;
                if ($urandom_range(0, 9) == 0)
                    wait_results_drained();
            end
        end
        sender_paced = 1'b1;
    endtask

    // check mode: mostly valid codewords, some with one bit flipped, some noise
    task automatic test_random_check();
        logic [5:0]  degree;
        logic [63:0] keep;
        logic [63:0] taps;
        logic [63:0] r;
        logic [63:0] msg;
        logic [63:0] frame;
        logic        top;
        int          d;
        int          mlen;
        int          flen;
        int          frames;
        int          kind;
        frames = 0;
        for (int phase = 0; frames < 8; phase++)
        begin
            case (phase)
                0:       degree = 6'd32;
                1:       degree = 6'd0;
                2:       degree = 6'd40;
                default: degree = 6'($urandom_range(1, 8));
            endcase
            configure(random_taps(), degree, JOB_CHECK);
            d    = active_degree();
            keep = (64'd1 << d) - 64'd1;
            taps = {32'b0, gen_taps} & keep;
            for (int f = 0; f < 2; f++)
            begin
                kind = $urandom_range(0, 9);
                if (kind < 2)
                begin
                    frame = {$urandom, $urandom};
                    flen  = $urandom_range(1, 12);
                end
                else
                begin
                    // message followed by its remainder divides to zero
                    msg  = {32'b0, $urandom};
                    mlen = $urandom_range(1, 6);
                    r    = '0;
                    for (int i = mlen - 1; i >= 0; i--)
                    begin
                        top = r[d-1];
                        r   = (r << 1) & keep;
                        if (top ^ msg[i])
                            r ^= taps;
                    end
                    frame = ((msg & ((64'd1 << mlen) - 64'd1)) << d) | r;
                    flen  = mlen + d;
                    if (kind < 4)
                        frame ^= 64'd1 << $urandom_range(0, flen - 1);
                end
                send_frame(frame, flen);
                frames++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        gen_taps          = 32'd7;
        gen_degree_reg    = 6'd8;
        gen_mode          = JOB_ECHO;
        running_remainder = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_degree_extremes();
        test_check_basics();
        test_midframe_reconfig();
        test_unused_index();
        test_random_encode();
        test_backpressure();
        test_random_check();

        wait_results_drained();
        if (mismatches == 0)
            $display("PASS crc_serial_encode_check");
        else
            $display("FAIL crc_serial_encode_check");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("FAIL crc_serial_encode_check");
        $finish;
    end

endmodule
